// File: hdl/dctb_pkg.sv
`default_nettype none

package dctb_pkg;

   localparam int TIME_W      = 63;
   localparam int NOW_FIELD_W = 63;
   localparam int QUOTA_W     = 16;
   localparam int LEVEL_W     = 52;
   localparam int EL_W        = 36;
   localparam int CMP_W       = (TIME_W > EL_W) ? TIME_W : EL_W;

   localparam logic [EL_W-1:0] TOKEN_UNITS = 36'd60000000000;
   localparam logic [EL_W-1:0] MAX_ELAPSED = 36'd60000000000;

   localparam logic [QUOTA_W-1:0] RESET_QUOTA = 16'd60;
   localparam logic [LEVEL_W-1:0] RESET_CAP   = LEVEL_W'(64'd60 * 64'd60000000000);

   // One token is DIV_D << DIV_SHIFT units, so the shift is taken first.
   localparam int              DIV_SHIFT = 11;
   localparam logic [24:0]     DIV_D     = 25'd29296875;
   localparam int              REM_W     = LEVEL_W - DIV_SHIFT;
   localparam int              QUOT_W    = QUOTA_W;

   // The top EST_W level bits times DIV_RECIP, shifted down by RECIP_SHIFT, give the
   // whole tokens or one less.
   localparam int               EST_SHIFT   = 20;
   localparam int               EST_W       = LEVEL_W - EST_SHIFT;
   localparam logic [EST_W-1:0] DIV_RECIP   = 32'd2459565876;
   localparam int               RECIP_SHIFT = 47;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = QUOTA_W;
   localparam int REQ_DATA_W = ((NOW_FIELD_W + 7) / 8) * 8;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = ((1 + 2 * QUOTA_W + 7) / 8) * 8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_NORMAL_QUOTA   = 1'b0,
      REG_RESERVED_QUOTA = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic               granted;
      logic [LEVEL_W-1:0] level_n;
      logic [LEVEL_W-1:0] level_r;
   } level_word_type;

   typedef struct packed {
      logic               grant;
      logic [LEVEL_W-1:0] level;
   } bucket_upd_type;

endpackage

`default_nettype wire

// File: hdl/dctb_front.sv
`default_nettype none

module dctb_front
   import dctb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TIME_W-1:0]     req_now,
   input  logic                  req_cls,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  out_valid,
   input  logic                  out_ready,
   output level_word_type        out_word
);

   function automatic bucket_upd_type bucket_step(
      input logic [LEVEL_W-1:0] level,
      input logic [LEVEL_W-1:0] inc,
      input logic [LEVEL_W-1:0] cap,
      input logic               take
   );
      logic [LEVEL_W:0]   sum;
      logic [LEVEL_W+1:0] sum_m;
      logic [LEVEL_W:0]   cap_m;
      logic               full;
      logic               ok;
      bucket_upd_type     r;
      sum   = {1'b0, level} + {1'b0, inc};
      sum_m = {2'b00, level} + {2'b00, inc} - (LEVEL_W + 2)'(TOKEN_UNITS);
      cap_m = {1'b0, cap} - (LEVEL_W + 1)'(TOKEN_UNITS);
      full  = (sum >= {1'b0, cap});
      if (full) begin
         ok = !cap_m[LEVEL_W];
      end else begin
         ok = !sum_m[LEVEL_W+1];
      end
      r.grant = take && ok;
      if (full) begin
         r.level = r.grant ? cap_m[LEVEL_W-1:0] : cap;
      end else begin
         r.level = r.grant ? sum_m[LEVEL_W-1:0] : sum[LEVEL_W-1:0];
      end
      return r;
   endfunction

   logic a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in, d_valid_ff, d_valid_in;
   logic a_ready, b_ready, c_ready, d_ready;
   logic a_load, b_load, c_load, d_load;

   logic [TIME_W-1:0]         a_now_ff;
   logic                      a_cls_ff;
   logic [EL_W-1:0]           b_elapsed_ff, b_elapsed_in;
   logic                      b_cls_ff;
   logic [LEVEL_W-1:0]        c_inc_n_ff, c_inc_r_ff;
   logic                      c_cls_ff;
   level_word_type            d_word_ff, d_word_in;

   logic [TIME_W-1:0]         last_ff, last_in;
   logic [QUOTA_W-1:0]        quota_n_ff, quota_n_in, quota_r_ff, quota_r_in;
   logic [LEVEL_W-1:0]        cap_n_ff, cap_n_in, cap_r_ff, cap_r_in;
   logic [LEVEL_W-1:0]        level_n_ff, level_n_in, level_r_ff, level_r_in;

   logic                      advanced;
   logic [CMP_W-1:0]          diff_ext;
   logic [EL_W+QUOTA_W-1:0]   prod_n, prod_r;
   logic [LEVEL_W-1:0]        wr_cap;
   bucket_upd_type            upd_n, upd_r;

   assign d_ready = !d_valid_ff || out_ready;
   assign c_ready = !c_valid_ff || d_ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;

   assign a_load = req_valid && a_ready;
   assign b_load = a_valid_ff && b_ready;
   assign c_load = b_valid_ff && c_ready;
   assign d_load = c_valid_ff && d_ready;

   assign a_valid_in = a_ready ? req_valid  : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;
   assign d_valid_in = d_ready ? c_valid_ff : d_valid_ff;

   assign req_ready = a_ready;
   assign out_valid = d_valid_ff;
   assign out_word  = d_word_ff;

   always_comb begin
      advanced = (a_now_ff > last_ff);
      diff_ext = CMP_W'(a_now_ff - last_ff);
      if (!advanced) begin
         b_elapsed_in = '0;
      end else if (diff_ext > CMP_W'(MAX_ELAPSED)) begin
         b_elapsed_in = MAX_ELAPSED;
      end else begin
         b_elapsed_in = EL_W'(diff_ext);
      end
      last_in = (b_load && advanced) ? a_now_ff : last_ff;
   end

   assign prod_n = (EL_W + QUOTA_W)'(b_elapsed_ff) * (EL_W + QUOTA_W)'(quota_n_ff);
   assign prod_r = (EL_W + QUOTA_W)'(b_elapsed_ff) * (EL_W + QUOTA_W)'(quota_r_ff);
   assign wr_cap = LEVEL_W'(csr_wdata) * LEVEL_W'(TOKEN_UNITS);

   always_comb begin
      upd_n = bucket_step(level_n_ff, c_inc_n_ff, cap_n_ff, !c_cls_ff);
      upd_r = bucket_step(level_r_ff, c_inc_r_ff, cap_r_ff, c_cls_ff);
      d_word_in.granted = upd_n.grant || upd_r.grant;
      d_word_in.level_n = upd_n.level;
      d_word_in.level_r = upd_r.level;

      quota_n_in = quota_n_ff;
      quota_r_in = quota_r_ff;
      cap_n_in   = cap_n_ff;
      cap_r_in   = cap_r_ff;
      level_n_in = d_load ? upd_n.level : level_n_ff;
      level_r_in = d_load ? upd_r.level : level_r_ff;
      if (csr_we) begin
         case (csr_reg_type'(csr_addr))
            REG_NORMAL_QUOTA: begin
               quota_n_in = csr_wdata;
               cap_n_in   = wr_cap;
               level_n_in = wr_cap;
            end
            REG_RESERVED_QUOTA: begin
               quota_r_in = csr_wdata;
               cap_r_in   = wr_cap;
               level_r_in = wr_cap;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         last_ff    <= '0;
         quota_n_ff <= RESET_QUOTA;
         quota_r_ff <= RESET_QUOTA;
         cap_n_ff   <= RESET_CAP;
         cap_r_ff   <= RESET_CAP;
         level_n_ff <= RESET_CAP;
         level_r_ff <= RESET_CAP;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         last_ff    <= last_in;
         quota_n_ff <= quota_n_in;
         quota_r_ff <= quota_r_in;
         cap_n_ff   <= cap_n_in;
         cap_r_ff   <= cap_r_in;
         level_n_ff <= level_n_in;
         level_r_ff <= level_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_now_ff <= req_now;
         a_cls_ff <= req_cls;
      end
      if (b_load) begin
         b_elapsed_ff <= b_elapsed_in;
         b_cls_ff     <= a_cls_ff;
      end
      if (c_load) begin
         c_inc_n_ff <= LEVEL_W'(prod_n);
         c_inc_r_ff <= LEVEL_W'(prod_r);
         c_cls_ff   <= b_cls_ff;
      end
      if (d_load) begin
         d_word_ff <= d_word_in;
      end
   end

   // A bucket never holds more than its capacity.
   a_level_n_cap: assert property (@(posedge clock) disable iff (reset)
      level_n_ff <= cap_n_ff)
      else $error("normal bucket level above capacity");

   a_level_r_cap: assert property (@(posedge clock) disable iff (reset)
      level_r_ff <= cap_r_ff)
      else $error("reserved bucket level above capacity");

   a_last_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> last_ff >= $past(last_ff))
      else $error("last refill time moved backward");

endmodule

`default_nettype wire

// File: hdl/dctb_tokdiv.sv
`default_nettype none

module dctb_tokdiv
   import dctb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  level_word_type    in_word,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_granted,
   output logic [QUOT_W-1:0] out_normal_left,
   output logic [QUOT_W-1:0] out_reserved_left
);

   // The estimate is never too large and at most one short.
   function automatic logic [QUOT_W-1:0] quot_fix(
      input logic [REM_W-1:0]  num,
      input logic [QUOT_W-1:0] est
   );
      logic [REM_W-1:0] rem;
      rem = num - REM_W'(est) * REM_W'(DIV_D);
      return (rem >= REM_W'(DIV_D)) ? est + QUOT_W'(1) : est;
   endfunction

   logic                          s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic                          s1_ready, s2_ready, s1_load, s2_load;
   logic                          s1_grant_ff, s2_grant_ff;
   logic [REM_W-1:0]              s1_num_n_ff, s1_num_r_ff;
   logic [QUOT_W-1:0]             s1_est_n_ff, s1_est_n_in, s1_est_r_ff, s1_est_r_in;
   logic [QUOT_W-1:0]             s2_quo_n_ff, s2_quo_n_in, s2_quo_r_ff, s2_quo_r_in;
   logic [RECIP_SHIFT+QUOT_W-1:0] prod_n, prod_r;

   assign s2_ready    = !s2_valid_ff || out_ready;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign s1_load     = in_valid && s1_ready;
   assign s2_load     = s1_valid_ff && s2_ready;
   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   assign prod_n = (RECIP_SHIFT + QUOT_W)'(in_word.level_n[LEVEL_W-1:EST_SHIFT])
                 * (RECIP_SHIFT + QUOT_W)'(DIV_RECIP);
   assign prod_r = (RECIP_SHIFT + QUOT_W)'(in_word.level_r[LEVEL_W-1:EST_SHIFT])
                 * (RECIP_SHIFT + QUOT_W)'(DIV_RECIP);

   assign s1_est_n_in = prod_n[RECIP_SHIFT +: QUOT_W];
   assign s1_est_r_in = prod_r[RECIP_SHIFT +: QUOT_W];
   assign s2_quo_n_in = quot_fix(s1_num_n_ff, s1_est_n_ff);
   assign s2_quo_r_in = quot_fix(s1_num_r_ff, s1_est_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_grant_ff <= in_word.granted;
         s1_num_n_ff <= in_word.level_n[LEVEL_W-1:DIV_SHIFT];
         s1_num_r_ff <= in_word.level_r[LEVEL_W-1:DIV_SHIFT];
         s1_est_n_ff <= s1_est_n_in;
         s1_est_r_ff <= s1_est_r_in;
      end
      if (s2_load) begin
         s2_grant_ff <= s1_grant_ff;
         s2_quo_n_ff <= s2_quo_n_in;
         s2_quo_r_ff <= s2_quo_r_in;
      end
   end

   assign in_ready          = s1_ready;
   assign out_valid         = s2_valid_ff;
   assign out_granted       = s2_grant_ff;
   assign out_normal_left   = s2_quo_n_ff;
   assign out_reserved_left = s2_quo_r_ff;

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid
         && $stable({out_granted, out_normal_left, out_reserved_left}))
      else $error("result word changed while stalled");

endmodule

`default_nettype wire

// File: hdl/dual_class_token_bucket.sv
`default_nettype none

// Two token buckets, normal and reserved, each refilled at its quota per minute up to a
// capacity of one minute's quota; a request word takes one token from the bucket of its
// class when one is there. The block takes one word per clock while its output is not
// stalled and presents the answer through six register stages: input register, elapsed
// time, refill multiply, bucket update, a reciprocal multiply that estimates the whole
// tokens in each bucket, and a correction step that feeds the output register. A stalled
// output holds the pipeline only as far back as its bubbles allow. Quota writes refill that
// bucket to full; the user makes them while no word is in flight, unchecked by the block.

module dual_class_token_bucket
   import dctb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // now_time
   input  logic [REQ_USER_W-1:0] req_tuser,   // traffic_class
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // granted, normal_left, reserved_left
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic              fr_valid;
   logic              dv_ready;
   level_word_type    fr_word;
   logic              dv_granted;
   logic [QUOT_W-1:0] dv_normal_left;
   logic [QUOT_W-1:0] dv_reserved_left;

   dctb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_now   (req_tdata[TIME_W-1:0]),
      .req_cls   (req_tuser[0]),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .out_valid (fr_valid),
      .out_ready (dv_ready),
      .out_word  (fr_word)
   );

   dctb_tokdiv u_tokdiv (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (fr_valid),
      .in_ready          (dv_ready),
      .in_word           (fr_word),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_granted       (dv_granted),
      .out_normal_left   (dv_normal_left),
      .out_reserved_left (dv_reserved_left)
   );

   assign rsp_tdata = RSP_DATA_W'({dv_reserved_left, dv_normal_left, dv_granted});

endmodule

`default_nettype wire
